// File: rtl/core/mdio_bu_pkg.sv
package mdio_bu_pkg;

  localparam int unsigned RESET_TIMEOUT_MS = 1000;
  localparam logic [31:0] LINK_TIMEOUT_RST = 32'd5000;

  localparam logic [2:0] CMD_START_BRINGUP = 3'd0;
  localparam logic [2:0] CMD_START_POLL    = 3'd1;
  localparam logic [2:0] CMD_READ_RESP     = 3'd2;
  localparam logic [2:0] CMD_WRITE_RESP    = 3'd3;
  localparam logic [2:0] CMD_TICK          = 3'd4;

  localparam logic [1:0] KIND_READ   = 2'd0;
  localparam logic [1:0] KIND_WRITE  = 2'd1;
  localparam logic [1:0] KIND_REPORT = 2'd2;

  localparam logic [1:0] STAT_OK           = 2'd0;
  localparam logic [1:0] STAT_ERROR        = 2'd1;
  localparam logic [1:0] STAT_LINK_TIMEOUT = 2'd2;

  localparam logic [4:0] MII_CTRL  = 5'h00;
  localparam logic [4:0] MII_STAT  = 5'h01;
  localparam logic [4:0] MII_ID_HI = 5'h02;
  localparam logic [4:0] MII_ID_LO = 5'h03;
  localparam logic [4:0] MII_ADV   = 5'h04;
  localparam logic [4:0] MII_SPCS  = 5'h1F;

  localparam logic [15:0] PREFERRED_ID1 = 16'h0007;
  localparam logic [15:0] ID_ALL_ONES   = 16'hFFFF;
  localparam logic [15:0] ID_ALL_ZEROS  = 16'h0000;
  localparam logic [15:0] BMCR_SOFT_RST = 16'h8000;
  localparam logic [15:0] BMCR_AN_RESTART = 16'h1000 | 16'h0200;
  localparam logic [15:0] ANAR_VALUE    = 16'h01E1;

  localparam int unsigned BMCR_RST_BIT  = 15;
  localparam int unsigned BMSR_LINK_BIT = 2;

  // SCSR[4:2] speed/duplex codes
  localparam logic [2:0] SCSR_10_HALF  = 3'b001;
  localparam logic [2:0] SCSR_100_HALF = 3'b010;
  localparam logic [2:0] SCSR_10_FULL  = 3'b101;
  localparam logic [2:0] SCSR_100_FULL = 3'b110;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_SCAN_ID1  = 4'd1,
    PH_SCAN_ID2  = 4'd2,
    PH_RST_WR    = 4'd3,
    PH_RST_POLL  = 4'd4,
    PH_ANAR_WR   = 4'd5,
    PH_AN_WR     = 4'd6,
    PH_LINK_BMSR = 4'd7,
    PH_LINK_SCSR = 4'd8,
    PH_POLL_BMSR = 4'd9,
    PH_POLL_SCSR = 4'd10
  } phase_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [4:0]  poll_addr;
    logic        resp_error;
    logic [15:0] resp_data;
  } evt_word_t;

  typedef struct packed {
    logic [1:0]  req_kind;
    logic [4:0]  req_phy;
    logic [4:0]  req_reg;
    logic [15:0] wr_data;
    logic [1:0]  status;
    logic        found;
    logic [4:0]  found_addr;
    logic [15:0] id_high;
    logic [15:0] id_low;
    logic        link_up;
    logic        fast_mode;
    logic        fdx;
  } req_word_t;

endpackage

// File: rtl/core/mdio_bu_evt_if.sv
interface mdio_bu_evt_if;
  logic                  valid;
  logic                  ready;
  mdio_bu_pkg::evt_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mdio_bu_req_if.sv
interface mdio_bu_req_if;
  logic                  valid;
  logic                  ready;
  mdio_bu_pkg::req_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/mdio_phy_bringup_sequencer_top.sv
// Clause-22 MDIO PHY bring-up and status sequencer.
// evt_ch carries event words: bring-up start, status-poll start, MDIO read
// and write responses, and a 1 ms tick. req_ch carries one word per event
// at most: an MDIO read or write request, or a final report with the chosen
// PHY, link, speed and duplex. The MDIO engine is outside this block; it
// executes each request and returns the response on evt_ch.
// The result of an event is registered and appears on req_ch in the cycle
// after the event word is accepted. Throughput: one event word per cycle
// while req_ch does not stall, set by the single registered decision stage;
// the output register frees each cycle it is taken.
// When req_ch stalls with a word pending, evt_ch.ready drops until that
// word is taken; no event is lost. cfg_we/cfg_wdata write the link timeout
// (ms); the user must write them only while idle; the block does not enforce it.
// rst (synchronous) returns to idle, clears scan and PHY state and the ms
// counter, empties the output register and loads a 5000 ms link timeout.
module mdio_phy_bringup_sequencer_top (
  input  logic                 clk,
  input  logic                 rst,
  mdio_bu_evt_if.sink          evt_ch,
  mdio_bu_req_if.source        req_ch,
  input  logic                 cfg_we,
  input  logic [31:0]          cfg_wdata
);

  mdio_bu_pkg::phase_t phase, phase_next;
  logic [5:0]  scan_index, scan_index_next;
  logic        fallback_valid, fallback_valid_next;
  logic [4:0]  fallback_addr, fallback_addr_next;
  logic [15:0] pending_id_high, pending_id_high_next;
  logic [4:0]  chosen_addr, chosen_addr_next;
  logic [15:0] chosen_id_high, chosen_id_high_next;
  logic [15:0] chosen_id_low, chosen_id_low_next;
  logic [31:0] elapsed_ms, elapsed_ms_next;
  logic        bmsr_second_read, bmsr_second_read_next;
  logic [31:0] link_timeout_ms;

  logic                   out_valid;
  mdio_bu_pkg::req_word_t out_word;
  mdio_bu_pkg::req_word_t res;
  logic                   res_valid;
  logic                   acc;

  // decision flags
  logic        scan_nx;
  logic [5:0]  scan_inc;
  logic        rq;
  logic [1:0]  rq_kind;
  logic [4:0]  rq_phy;
  logic [4:0]  rq_reg;
  logic [15:0] rq_data;
  logic        rep;
  logic [1:0]  rep_status;
  logic        rep_bring;
  logic        rep_found;
  logic        rep_link;
  logic        rep_decode;
  logic [2:0]  scsr_code;

  assign evt_ch.ready = !out_valid || req_ch.ready;
  assign acc          = evt_ch.valid && evt_ch.ready;
  assign req_ch.valid = out_valid;
  assign req_ch.data  = out_word;
  assign scan_inc     = scan_index + 6'd1;
  assign scsr_code    = evt_ch.data.resp_data[4:2];

  always_comb begin
    phase_next            = phase;
    scan_index_next       = scan_index;
    fallback_valid_next   = fallback_valid;
    fallback_addr_next    = fallback_addr;
    pending_id_high_next  = pending_id_high;
    chosen_addr_next      = chosen_addr;
    chosen_id_high_next   = chosen_id_high;
    chosen_id_low_next    = chosen_id_low;
    elapsed_ms_next       = elapsed_ms;
    bmsr_second_read_next = bmsr_second_read;
    scan_nx    = 1'b0;
    rq         = 1'b0;
    rq_kind    = mdio_bu_pkg::KIND_READ;
    rq_phy     = '0;
    rq_reg     = '0;
    rq_data    = '0;
    rep        = 1'b0;
    rep_status = mdio_bu_pkg::STAT_OK;
    rep_bring  = 1'b0;
    rep_found  = 1'b0;
    rep_link   = 1'b0;
    rep_decode = 1'b0;
    res        = '0;
    res_valid  = 1'b0;

    if (acc) begin
      unique case (evt_ch.data.cmd)
        mdio_bu_pkg::CMD_START_BRINGUP: begin
          scan_index_next       = '0;
          fallback_valid_next   = 1'b0;
          fallback_addr_next    = '0;
          pending_id_high_next  = '0;
          chosen_addr_next      = '0;
          chosen_id_high_next   = '0;
          chosen_id_low_next    = '0;
          bmsr_second_read_next = 1'b0;
          phase_next            = mdio_bu_pkg::PH_SCAN_ID1;
          rq     = 1'b1;
          rq_phy = '0;
          rq_reg = mdio_bu_pkg::MII_ID_HI;
        end
        mdio_bu_pkg::CMD_START_POLL: begin
          chosen_addr_next      = evt_ch.data.poll_addr;
          bmsr_second_read_next = 1'b0;
          phase_next            = mdio_bu_pkg::PH_POLL_BMSR;
          rq     = 1'b1;
          rq_phy = evt_ch.data.poll_addr;
          rq_reg = mdio_bu_pkg::MII_STAT;
        end
        mdio_bu_pkg::CMD_READ_RESP: begin
          unique case (phase)
            mdio_bu_pkg::PH_SCAN_ID1: begin
              if (evt_ch.data.resp_error
                  || evt_ch.data.resp_data == mdio_bu_pkg::ID_ALL_ONES
                  || evt_ch.data.resp_data == mdio_bu_pkg::ID_ALL_ZEROS) begin
                scan_nx = 1'b1;
              end else begin
                pending_id_high_next = evt_ch.data.resp_data;
                phase_next = mdio_bu_pkg::PH_SCAN_ID2;
                rq     = 1'b1;
                rq_phy = scan_index[4:0];
                rq_reg = mdio_bu_pkg::MII_ID_LO;
              end
            end
            mdio_bu_pkg::PH_SCAN_ID2: begin
              if (evt_ch.data.resp_error) begin
                scan_nx = 1'b1;
              end else if (pending_id_high == mdio_bu_pkg::PREFERRED_ID1) begin
                chosen_addr_next    = scan_index[4:0];
                chosen_id_high_next = pending_id_high;
                chosen_id_low_next  = evt_ch.data.resp_data;
                phase_next = mdio_bu_pkg::PH_RST_WR;
                rq      = 1'b1;
                rq_kind = mdio_bu_pkg::KIND_WRITE;
                rq_phy  = scan_index[4:0];
                rq_reg  = mdio_bu_pkg::MII_CTRL;
                rq_data = mdio_bu_pkg::BMCR_SOFT_RST;
              end else begin
                if (!fallback_valid) begin
                  fallback_valid_next = 1'b1;
                  fallback_addr_next  = scan_index[4:0];
                  chosen_id_high_next = pending_id_high;
                  chosen_id_low_next  = evt_ch.data.resp_data;
                end
                scan_nx = 1'b1;
              end
            end
            mdio_bu_pkg::PH_RST_POLL: begin
              priority if (evt_ch.data.resp_error) begin
                rep        = 1'b1;
                rep_status = mdio_bu_pkg::STAT_ERROR;
                rep_bring  = 1'b1;
                rep_found  = 1'b1;
              end else if (!evt_ch.data.resp_data[mdio_bu_pkg::BMCR_RST_BIT]) begin
                phase_next = mdio_bu_pkg::PH_ANAR_WR;
                rq      = 1'b1;
                rq_kind = mdio_bu_pkg::KIND_WRITE;
                rq_phy  = chosen_addr;
                rq_reg  = mdio_bu_pkg::MII_ADV;
                rq_data = mdio_bu_pkg::ANAR_VALUE;
              end else if (elapsed_ms < 32'(mdio_bu_pkg::RESET_TIMEOUT_MS)) begin
                rq     = 1'b1;
                rq_phy = chosen_addr;
                rq_reg = mdio_bu_pkg::MII_CTRL;
              end else begin
                rep        = 1'b1;
                rep_status = mdio_bu_pkg::STAT_ERROR;
                rep_bring  = 1'b1;
                rep_found  = 1'b1;
              end
            end
            mdio_bu_pkg::PH_LINK_BMSR, mdio_bu_pkg::PH_POLL_BMSR: begin
              priority if (evt_ch.data.resp_error) begin
                rep        = 1'b1;
                rep_status = mdio_bu_pkg::STAT_ERROR;
                rep_bring  = (phase == mdio_bu_pkg::PH_LINK_BMSR);
                rep_found  = 1'b1;
              end else if (!bmsr_second_read) begin
                bmsr_second_read_next = 1'b1;
                rq     = 1'b1;
                rq_phy = chosen_addr;
                rq_reg = mdio_bu_pkg::MII_STAT;
              end else if (evt_ch.data.resp_data[mdio_bu_pkg::BMSR_LINK_BIT]) begin
                bmsr_second_read_next = 1'b0;
                phase_next = (phase == mdio_bu_pkg::PH_LINK_BMSR) ?
                             mdio_bu_pkg::PH_LINK_SCSR : mdio_bu_pkg::PH_POLL_SCSR;
                rq     = 1'b1;
                rq_phy = chosen_addr;
                rq_reg = mdio_bu_pkg::MII_SPCS;
              end else if (phase == mdio_bu_pkg::PH_POLL_BMSR) begin
                bmsr_second_read_next = 1'b0;
                rep        = 1'b1;
                rep_status = mdio_bu_pkg::STAT_OK;
              end else if (elapsed_ms >= link_timeout_ms) begin
                bmsr_second_read_next = 1'b0;
                rep        = 1'b1;
                rep_status = mdio_bu_pkg::STAT_LINK_TIMEOUT;
                rep_bring  = 1'b1;
                rep_found  = 1'b1;
              end else begin
                bmsr_second_read_next = 1'b0;
                rq     = 1'b1;
                rq_phy = chosen_addr;
                rq_reg = mdio_bu_pkg::MII_STAT;
              end
            end
            mdio_bu_pkg::PH_LINK_SCSR, mdio_bu_pkg::PH_POLL_SCSR: begin
              rep        = 1'b1;
              rep_bring  = (phase == mdio_bu_pkg::PH_LINK_SCSR);
              rep_found  = 1'b1;
              rep_link   = 1'b1;
              rep_status = evt_ch.data.resp_error ?
                           mdio_bu_pkg::STAT_ERROR : mdio_bu_pkg::STAT_OK;
              rep_decode = !evt_ch.data.resp_error;
            end
            default: begin
            end
          endcase
        end
        mdio_bu_pkg::CMD_WRITE_RESP: begin
          if (phase == mdio_bu_pkg::PH_RST_WR || phase == mdio_bu_pkg::PH_ANAR_WR
              || phase == mdio_bu_pkg::PH_AN_WR) begin
            priority if (evt_ch.data.resp_error) begin
              rep        = 1'b1;
              rep_status = mdio_bu_pkg::STAT_ERROR;
              rep_bring  = 1'b1;
              rep_found  = 1'b1;
            end else if (phase == mdio_bu_pkg::PH_RST_WR) begin
              elapsed_ms_next = '0;
              phase_next = mdio_bu_pkg::PH_RST_POLL;
              rq     = 1'b1;
              rq_phy = chosen_addr;
              rq_reg = mdio_bu_pkg::MII_CTRL;
            end else if (phase == mdio_bu_pkg::PH_ANAR_WR) begin
              phase_next = mdio_bu_pkg::PH_AN_WR;
              rq      = 1'b1;
              rq_kind = mdio_bu_pkg::KIND_WRITE;
              rq_phy  = chosen_addr;
              rq_reg  = mdio_bu_pkg::MII_CTRL;
              rq_data = mdio_bu_pkg::BMCR_AN_RESTART;
            end else begin
              elapsed_ms_next       = '0;
              bmsr_second_read_next = 1'b0;
              phase_next = mdio_bu_pkg::PH_LINK_BMSR;
              rq     = 1'b1;
              rq_phy = chosen_addr;
              rq_reg = mdio_bu_pkg::MII_STAT;
            end
          end
        end
        mdio_bu_pkg::CMD_TICK: begin
          if (elapsed_ms != '1) begin
            elapsed_ms_next = elapsed_ms + 32'd1;
          end
        end
        default: begin
        end
      endcase
    end

    // advance scan to the next address, or pick the fallback PHY, or report an error if none was found
    if (scan_nx) begin
      scan_index_next = scan_inc;
      priority if (!scan_inc[5]) begin
        phase_next = mdio_bu_pkg::PH_SCAN_ID1;
        rq     = 1'b1;
        rq_phy = scan_inc[4:0];
        rq_reg = mdio_bu_pkg::MII_ID_HI;
      end else if (fallback_valid_next) begin
        chosen_addr_next = fallback_addr_next;
        phase_next = mdio_bu_pkg::PH_RST_WR;
        rq      = 1'b1;
        rq_kind = mdio_bu_pkg::KIND_WRITE;
        rq_phy  = fallback_addr_next;
        rq_reg  = mdio_bu_pkg::MII_CTRL;
        rq_data = mdio_bu_pkg::BMCR_SOFT_RST;
      end else begin
        rep        = 1'b1;
        rep_status = mdio_bu_pkg::STAT_ERROR;
        rep_bring  = 1'b1;
        rep_found  = 1'b0;
      end
    end

    if (rq) begin
      res_valid   = 1'b1;
      res.req_kind = rq_kind;
      res.req_phy  = rq_phy;
      res.req_reg  = rq_reg;
      res.wr_data  = rq_data;
    end else if (rep) begin
      res_valid    = 1'b1;
      phase_next   = mdio_bu_pkg::PH_IDLE;
      res.req_kind = mdio_bu_pkg::KIND_REPORT;
      res.status   = rep_status;
      res.link_up  = rep_link;
      if (rep_bring) begin
        res.found      = rep_found;
        res.found_addr = rep_found ? chosen_addr_next : 5'd0;
        res.id_high    = chosen_id_high_next;
        res.id_low     = chosen_id_low_next;
      end
      if (rep_decode) begin
        res.fast_mode = (scsr_code == mdio_bu_pkg::SCSR_100_FULL)
                     || (scsr_code == mdio_bu_pkg::SCSR_100_HALF);
        res.fdx       = (scsr_code == mdio_bu_pkg::SCSR_100_FULL)
                     || (scsr_code == mdio_bu_pkg::SCSR_10_FULL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= mdio_bu_pkg::PH_IDLE;
      scan_index       <= '0;
      fallback_valid   <= 1'b0;
      fallback_addr    <= '0;
      pending_id_high  <= '0;
      chosen_addr      <= '0;
      chosen_id_high   <= '0;
      chosen_id_low    <= '0;
      elapsed_ms       <= '0;
      bmsr_second_read <= 1'b0;
      link_timeout_ms  <= mdio_bu_pkg::LINK_TIMEOUT_RST;
      out_valid        <= 1'b0;
    end else begin
      phase            <= phase_next;
      scan_index       <= scan_index_next;
      fallback_valid   <= fallback_valid_next;
      fallback_addr    <= fallback_addr_next;
      pending_id_high  <= pending_id_high_next;
      chosen_addr      <= chosen_addr_next;
      chosen_id_high   <= chosen_id_high_next;
      chosen_id_low    <= chosen_id_low_next;
      elapsed_ms       <= elapsed_ms_next;
      bmsr_second_read <= bmsr_second_read_next;
      if (cfg_we) begin
        link_timeout_ms <= cfg_wdata;
      end
      if (evt_ch.ready) begin
        out_valid <= res_valid;
      end
    end
  end

  // output word register, no reset needed
  always_ff @(posedge clk) begin
    if (evt_ch.ready) begin
      out_word <= res;
    end
  end

endmodule
